FILE: sv/fcmc_pkg.sv
// Package for the FIFO-replacement cache miss counter.
// Shared widths, defaults and the token type that travels along the cell row.
// No dependencies.
`default_nettype none

package fcmc_pkg;

  localparam int unsigned DepthDefault   = 128;
  localparam int unsigned KeyBitsDefault = 16;
  localparam int unsigned CapW           = 8;
  localparam int unsigned CapReset       = 128;
  localparam int unsigned MissW          = 32;
  // Output word: hit in bit 0, miss total above it, padded to whole bytes.
  localparam int unsigned OutW           = ((1 + MissW + 7) / 8) * 8;

  // Lookup token handed from cell to cell.
  typedef struct packed {
    logic valid;
    logic hit;
  } tok_t;

endpackage

`default_nettype wire

FILE: sv/fcmc_cell.sv
// One slot of the fully associative store: holds a key and compares the
// passing lookup against it. Depends on fcmc_pkg.
`default_nettype none

module fcmc_cell #(
  parameter int unsigned KEY_BITS = fcmc_pkg::KeyBitsDefault,
  parameter int unsigned CNT_W    = 8,
  parameter int unsigned IDX_W    = 7,
  parameter int unsigned IDX      = 0
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire fcmc_pkg::tok_t      tok_i,
  input  wire  [KEY_BITS-1:0]      key_i,
  input  wire  [CNT_W-1:0]         fill_i,
  input  wire                      we_i,
  input  wire  [IDX_W-1:0]         waddr_i,
  input  wire  [KEY_BITS-1:0]      wkey_i,
  output fcmc_pkg::tok_t           tok_o,
  output logic [KEY_BITS-1:0]      key_o
);

  logic [KEY_BITS-1:0] entry_q;
  fcmc_pkg::tok_t      tok_q, tok_d;
  logic                occupied;

  // Slots below the fill count hold written keys; the rest never produce a hit.
  assign occupied = (CNT_W'(IDX) < fill_i);

  always_comb begin
    tok_d.valid = tok_i.valid;
    tok_d.hit   = tok_i.hit | (tok_i.valid & occupied & (entry_q == key_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_o <= key_i;
    if (we_i && (waddr_i == IDX_W'(IDX))) begin
      entry_q <= wkey_i;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

FILE: sv/fifo_cache_miss_counter.sv
// Top level of the FIFO-replacement cache miss counter.
// Instantiates a row of fcmc_cell slots; depends on fcmc_pkg.
`default_nettype none

// Each key word walks down a row of DEPTH slot cells, one cell per clock, and
// collects a hit flag on the way; when it leaves the last cell the flag is
// registered, and once the output register is free the slot is written on a
// miss and the result word is loaded into the output register. Only one item
// is in the row at a time; the next key is taken once the result is loaded,
// even while that result still waits in the output register. A result still
// waiting there when the next item finishes holds that item back until the
// word is taken. A capacity write empties the store and keeps the miss count;
// capacity 0 acts as 1, and values above DEPTH act as DEPTH. The miss total
// saturates at all ones.
module fifo_cache_miss_counter #(
  parameter int unsigned DEPTH    = fcmc_pkg::DepthDefault,
  parameter int unsigned KEY_BITS = fcmc_pkg::KeyBitsDefault,
  localparam int unsigned IN_W    = ((KEY_BITS + 7) / 8) * 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration: capacity.
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [fcmc_pkg::CapW-1:0]    cfg_data_i,
  // Input word, bits from low: key.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [IN_W-1:0]              s_axis_tdata,
  // Output word, bits from low: hit, miss_total, zero padding.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [fcmc_pkg::OutW-1:0]    m_axis_tdata
);

  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W   = (CNT_W > fcmc_pkg::CapW) ? CNT_W : fcmc_pkg::CapW;
  localparam int unsigned EFF_RST = (DEPTH < fcmc_pkg::CapReset) ? DEPTH : fcmc_pkg::CapReset;
  localparam int unsigned PAD_W   = fcmc_pkg::OutW - 1 - fcmc_pkg::MissW;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  state_e                       state_q, state_d;
  logic [CNT_W-1:0]             eff_q, eff_d;
  logic [CNT_W-1:0]             fill_q, fill_d;
  logic [IDX_W-1:0]             oldest_q, oldest_d;
  logic [fcmc_pkg::MissW-1:0]   miss_q, miss_d;
  logic                         hit_q, hit_d;
  logic [KEY_BITS-1:0]          key_q;
  logic                         out_valid_q, out_valid_d;
  logic                         out_hit_q;
  logic [fcmc_pkg::MissW-1:0]   out_miss_q;

  fcmc_pkg::tok_t               chain_tok [DEPTH+1];
  logic [KEY_BITS-1:0]          chain_key [DEPTH+1];

  logic                         in_acc;
  logic                         cfg_acc;
  logic                         finish_go;
  logic                         we;
  logic [IDX_W-1:0]             waddr;
  logic [IDX_W-1:0]             old_sel;
  logic [CMP_W-1:0]             cap_ext;

  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i & cfg_ready_o;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign finish_go     = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
  assign we            = finish_go && !hit_q;

  // Head of the row.
  assign chain_tok[0].valid = in_acc;
  assign chain_tok[0].hit   = 1'b0;
  assign chain_key[0]       = s_axis_tdata[KEY_BITS-1:0];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    fcmc_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W),
      .IDX      (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .tok_i   (chain_tok[g]),
      .key_i   (chain_key[g]),
      .fill_i  (fill_q),
      .we_i    (we),
      .waddr_i (waddr),
      .wkey_i  (key_q),
      .tok_o   (chain_tok[g+1]),
      .key_o   (chain_key[g+1])
    );
  end

  // Replacement pointer wraps to slot zero if capacity shrank below it.
  assign old_sel = (CNT_W'(oldest_q) >= eff_q) ? '0 : oldest_q;
  assign waddr   = (fill_q < eff_q) ? fill_q[IDX_W-1:0] : old_sel;
  assign cap_ext = CMP_W'(cfg_data_i);

  always_comb begin
    state_d     = state_q;
    eff_d       = eff_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    miss_d      = miss_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_tok[DEPTH].valid) begin
          hit_d   = chain_tok[DEPTH].hit;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (!hit_q) begin
            if (fill_q < eff_q) begin
              fill_d = fill_q + 1'b1;
            end else begin
              oldest_d = ((CNT_W'(old_sel) + 1'b1) == eff_q) ? '0 : old_sel + 1'b1;
            end
            if (miss_q != '1) begin
              miss_d = miss_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_acc) begin
      fill_d   = '0;
      oldest_d = '0;
      priority if (cap_ext == '0) begin
        eff_d = CNT_W'(1);
      end else if (cap_ext > CMP_W'(DEPTH)) begin
        eff_d = CNT_W'(DEPTH);
      end else begin
        eff_d = cap_ext[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      eff_q       <= CNT_W'(EFF_RST);
      fill_q      <= '0;
      oldest_q    <= '0;
      miss_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      eff_q       <= eff_d;
      fill_q      <= fill_d;
      oldest_q    <= oldest_d;
      miss_q      <= miss_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      key_q <= s_axis_tdata[KEY_BITS-1:0];
    end
    if (finish_go) begin
      out_hit_q  <= hit_q;
      out_miss_q <= miss_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_miss_q, out_hit_q};

  // The lookup token leaves the row only while the sequencer waits for it.
  a_tok_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_tok[DEPTH].valid |-> (state_q == ST_SCAN))
    else $error("lookup token left the cell row outside the scan");

  // The fill count never passes the effective capacity.
  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= eff_q)
    else $error("fill count above capacity");

  // The miss count only moves up, and only when a missing item finishes.
  a_miss_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (miss_q != $past(miss_q)) |-> ($past(we) && (miss_q == $past(miss_q) + 1'b1)))
    else $error("miss count changed without a miss");

  // A finishing item always leaves a word in the output register.
  a_out_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish_go |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("finished item produced no output word");

endmodule

`default_nettype wire

FILE: tb/sv/fifo_cache_miss_counter_test.sv
// Testbench for the FIFO-replacement cache miss counter.
// Predicts hit flag and miss total per key and checks every result word in order.
// Depends on fcmc_pkg and fifo_cache_miss_counter.
`default_nettype none

module fifo_cache_miss_counter_test;

  localparam int unsigned DEPTH      = fcmc_pkg::DepthDefault;
  localparam int unsigned KEY_BITS   = fcmc_pkg::KeyBitsDefault;
  localparam int unsigned IN_W       = ((KEY_BITS + 7) / 8) * 8;
  localparam int unsigned CapW       = fcmc_pkg::CapW;
  localparam int unsigned MissW      = fcmc_pkg::MissW;
  localparam int unsigned OutW       = fcmc_pkg::OutW;
  localparam int unsigned PadW       = OutW - 1 - MissW;
  localparam int unsigned Latency    = DEPTH + 2;
  localparam int unsigned StallLimit = 20 * Latency;
  localparam int unsigned MaxPrints  = 30;

  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct {
    logic             hit;
    logic [MissW-1:0] miss_total;
  } lookup_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CapW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutW-1:0]     m_axis_tdata;

  // Predictor state: the cache contents as the block should hold them.
  key_t             slot_key [DEPTH];
  int unsigned      filled_slots    = 0;
  int unsigned      oldest_slot_ptr = 0;
  logic [CapW-1:0]  capacity_setting = CapW'(fcmc_pkg::CapReset);
  logic [MissW-1:0] miss_count      = '0;

  key_t        pending_keys[$];
  lookup_t     expected_lookups[$];
  int unsigned error_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned stall_cycles  = 0;

  fifo_cache_miss_counter #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // key
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)    // hit, miss_total, zero padding
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned effective_capacity();
    if (capacity_setting == 0) return 1;
    if (capacity_setting > DEPTH) return DEPTH;
    return 32'(capacity_setting);
  endfunction

  function automatic lookup_t predict_lookup(input key_t key);
    lookup_t     res;
    int unsigned cap;
    cap = effective_capacity();
    res.hit = 1'b0;
    for (int unsigned i = 0; i < filled_slots; i++) begin
      if (slot_key[i] == key) res.hit = 1'b1;
    end
    if (!res.hit) begin
      if (filled_slots < cap) begin
        slot_key[filled_slots] = key;
        filled_slots++;
      end else begin
        if (oldest_slot_ptr >= cap) oldest_slot_ptr = 0;
        slot_key[oldest_slot_ptr] = key;
        oldest_slot_ptr = (oldest_slot_ptr + 1 == cap) ? 0 : oldest_slot_ptr + 1;
      end
      if (miss_count != '1) miss_count++;
    end
    res.miss_total = miss_count;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [MissW-1:0] got,
                                 input logic [MissW-1:0] want);
    if (error_count < MaxPrints) begin
      $display("mismatch on %s at %0t: got 0x%0h, expected 0x%0h", field, $realtime, got, want);
    end
    error_count++;
  endtask

  // Driver: presents pending keys and predicts each one as it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_lookups.push_back(predict_lookup(s_axis_tdata[KEY_BITS-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= IN_W'(pending_keys.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result word against the oldest prediction.
  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata[MissW:1], '0);
      end else begin
        want = expected_lookups.pop_front();
        if (m_axis_tdata[0] !== want.hit) begin
          report_mismatch("hit", MissW'(m_axis_tdata[0]), MissW'(want.hit));
        end
        if (m_axis_tdata[MissW:1] !== want.miss_total) begin
          report_mismatch("miss_total", m_axis_tdata[MissW:1], want.miss_total);
        end
        if (m_axis_tdata[OutW-1:MissW+1] !== '0) begin
          report_mismatch("padding", MissW'(m_axis_tdata[OutW-1:MissW+1]), '0);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: any accepted word on any channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_keys.size() != 0 || s_axis_tvalid || expected_lookups.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Only called with the block idle; the write empties the store.
  task automatic set_capacity(input logic [CapW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i      <= 1'b0;
    capacity_setting = value;
    filled_slots     = 0;
    oldest_slot_ptr  = 0;
  endtask

  task automatic push_keys(input key_t keys[]);
    foreach (keys[i]) pending_keys.push_back(keys[i]);
    wait_drained();
  endtask

  initial begin
    logic [CapW-1:0] phase_caps [10];
    int unsigned     eff;
    int unsigned     pool;
    int unsigned     walk;
    int unsigned     pick;
    int unsigned     count;
    key_t            base;
    key_t            key;

    phase_caps = '{8'd128, 8'd1, 8'd3, 8'd16, 8'd200, 8'd0, 8'd64, 8'd2, 8'd255, 8'd0};
    phase_caps[9] = CapW'($urandom_range(1, DEPTH));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 17;
    recv_idle_pct = 76;

    // Reset capacity: extreme keys, hits on both.
    push_keys('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hAAAA});
    // Single entry: every new key replaces the only slot.
    set_capacity(8'd1);
    push_keys('{16'h0005, 16'h0005, 16'h0006, 16'h0005, 16'h0005});
    // Zero acts as one.
    set_capacity(8'd0);
    push_keys('{16'h0007, 16'h0007, 16'h8000, 16'h0007});
    // Two entries: replacement walks the oldest pointer around.
    set_capacity(8'd2);
    push_keys('{16'h0001, 16'h0002, 16'h0001, 16'h0003, 16'h0001, 16'h0002});
    // Above the depth acts as the depth; the write emptied the store.
    set_capacity(8'd255);
    push_keys('{16'hFFFF, 16'hFFFF});

    foreach (phase_caps[p]) begin
      if (p == 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 17;
      end else if (p == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_capacity(phase_caps[p]);
      eff   = effective_capacity();
      pool  = eff + eff / 4 + 1;
      count = (eff >= 64) ? 160 : 50;
      base  = key_t'($urandom_range(16'hFFFF));
      walk  = 0;
      // Mostly a working set a bit larger than the capacity, partly swept in
      // order to force steady replacement, with some unrelated keys mixed in.
      repeat (count) begin
        pick = $urandom_range(99);
        if (pick < 30) begin
          key  = key_t'(base + walk);
          walk = (walk + 1) % pool;
        end else if (pick < 85) begin
          key = key_t'(base + $urandom_range(pool - 1));
        end else begin
          key = key_t'($urandom_range(16'hFFFF));
        end
        pending_keys.push_back(key);
      end
      wait_drained();
    end

    repeat (Latency) @(posedge clk_i);
    if (error_count == 0 && expected_lookups.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
